// ----- hdl/fbc_pkg.sv -----
// Shared constants and types for the fill-boundary 1D convolution core.
// Used by fbc_mac, fbc_div and fill_boundary_convolution_1d_core.
`default_nettype none
package fbc_pkg;

    localparam int MAX_TAPS         = 63;
    localparam int TAP_AW           = 6;
    localparam int WIN_DEPTH        = 64;
    localparam int DEF_SAMPLE_BITS  = 24;
    localparam int DEF_COEF_BITS    = 18;
    localparam int VALUE_BITS       = 48;
    localparam int FRAC_BITS        = 16;
    localparam int MAX_RESULTS      = 32;
    localparam int ACC_GUARD        = 6;
    localparam int CFG_IDX_BITS     = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILL_VALUE   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILL_MISSING = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SKIP_FILL    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_NAN_MODE     = 3'd4;

    localparam logic REQ_TAP    = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic valid;
        logic miss;
        logic last;
    } fbc_tap_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/fill_boundary_convolution_1d_core.sv -----
// Fill-boundary 1D convolution core: top level with sequencer, tap and window
// memories. Instantiates fbc_mac and fbc_div; uses fbc_pkg.
//
// Usage: write half width, fill sample, fill-missing flag, skip-outside flag
// and NaN mode over the cfg channel while idle. On s_, tuser=0 writes one
// kernel tap and tuser=1 delivers one row sample; tlast marks the last sample
// of a row. A sample releases every output whose right neighbors have arrived;
// the last sample flushes all pending outputs (at most 32 per sample). Results
// leave on m_ with tlast on the output for the row's last sample in the final flush.
// Each output runs 2*half_width+1 taps through the shared multiply-accumulate
// and its pipeline before the handoff; in NaN mode with a nonzero weight sum
// the serial divider runs as well. s_tready is high only while no sample is
// in work. The output register decouples m_: a stalled receiver holds one
// result and stops the sequencer before the next one.
// Reset clears configuration to its defaults and empties the row; kernel taps
// stay undefined until written.
`default_nettype none
module fill_boundary_convolution_1d_core
    import fbc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = DEF_COEF_BITS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // tap_index, coefficient, sample, sample_missing (from bit 0), zero padded
    input  wire logic [((TAP_AW+COEF_BITS+SAMPLE_BITS+1+7)/8)*8-1:0] s_tdata,
    input  wire logic                      s_tuser, // req_type
    input  wire logic                      s_tlast, // last_sample
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // value, value_missing (from bit 0), zero padded
    output logic [((VALUE_BITS+1+7)/8)*8-1:0] m_tdata,
    output logic                           m_tlast, // last_result
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [SAMPLE_BITS-1:0]    cfg_data
);

    localparam int OUT_TW   = ((VALUE_BITS + 1 + 7) / 8) * 8;
    localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + ACC_GUARD;
    localparam int BOT_BITS = COEF_BITS + ACC_GUARD;
    localparam int QUO_BITS = ACC_BITS + FRAC_BITS;
    localparam int CNT_BITS = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_EMIT  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_RES   = 3'd5;

    localparam logic signed [79:0] VMAX = 80'sh0000_00007FFF_FFFFFFFF;
    localparam logic signed [79:0] VMIN = -80'sh0000_00008000_00000000;

    logic [2:0] state_reg;

    logic [4:0]                    hw_reg;
    logic signed [SAMPLE_BITS-1:0] fill_reg;
    logic                          fill_miss_reg;
    logic                          skip_reg;
    logic                          nan_reg;

    logic [SAMPLE_BITS:0] win_mem [0:WIN_DEPTH-1];
    logic [COEF_BITS-1:0] tap_mem [0:MAX_TAPS-1];
    logic [SAMPLE_BITS:0] win_rd_reg;
    logic [COEF_BITS-1:0] tap_rd_reg;

    logic [TAP_AW-1:0]   wp_reg;
    logic [TAP_AW-1:0]   row_pos_reg;
    logic [TAP_AW-1:0]   pending_reg;
    logic [CNT_BITS-1:0] n_reg;
    logic                last_reg;
    logic [TAP_AW-1:0]   d_reg;
    logic [TAP_AW-1:0]   k_reg;

    logic s1_valid_reg, s1_outside_reg, s1_last_reg, s1_center_reg;
    logic signed [SAMPLE_BITS-1:0] centre_val_reg;
    logic                          centre_miss_reg;
    logic                          centre_in_reg;

    logic signed [VALUE_BITS-1:0] res_val_reg;
    logic                         res_miss_reg;
    logic                         neg_reg;

    logic                m_tvalid_reg;
    logic [OUT_TW-1:0]   m_tdata_reg;
    logic                m_tlast_reg;

    logic [TAP_AW-1:0]             in_tap_index;
    logic signed [COEF_BITS-1:0]   in_coef;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          in_missing;
    logic                          s_xfer;

    logic signed [7:0]   j;
    logic                outside;
    logic [TAP_AW-1:0]   win_addr;
    logic                emit_go;
    logic                mac_clr;
    fbc_tap_ctl_t        ctl;
    logic signed [SAMPLE_BITS-1:0] v_sel;
    logic                          m_sel;
    logic                          skip;

    logic                          mac_done;
    logic signed [ACC_BITS-1:0]    mac_top;
    logic signed [BOT_BITS-1:0]    mac_bot;
    logic                          mac_any_miss;

    logic                 div_start;
    logic                 div_done;
    logic [ACC_BITS-1:0]  div_num;
    logic [BOT_BITS-1:0]  div_den;
    logic [QUO_BITS-1:0]  div_quo;

    logic signed [79:0]   top_x;
    logic signed [79:0]   quo_x;
    logic                 out_free;

    assign in_tap_index = s_tdata[TAP_AW-1:0];
    assign in_coef      = s_tdata[TAP_AW +: COEF_BITS];
    assign in_sample    = s_tdata[TAP_AW+COEF_BITS +: SAMPLE_BITS];
    assign in_missing   = s_tdata[TAP_AW+COEF_BITS+SAMPLE_BITS];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign emit_go = (pending_reg != '0) && (n_reg < CNT_BITS'(MAX_RESULTS))
                     && (last_reg || ((pending_reg - 1'b1) >= {1'b0, hw_reg}));
    assign mac_clr = (state_reg == ST_CHECK) && emit_go;

    assign j        = 8'(d_reg) - 8'(hw_reg) + 8'(k_reg);
    assign outside  = j[7] || (j[6:0] >= 7'(row_pos_reg));
    assign win_addr = wp_reg - 1'b1 - j[TAP_AW-1:0];

    assign v_sel = s1_outside_reg ? fill_reg : win_rd_reg[SAMPLE_BITS-1:0];
    assign m_sel = s1_outside_reg ? fill_miss_reg : win_rd_reg[SAMPLE_BITS];
    assign skip  = s1_outside_reg && !nan_reg && skip_reg;
    assign ctl.valid = s1_valid_reg && !skip;
    assign ctl.miss  = m_sel;
    assign ctl.last  = s1_valid_reg && s1_last_reg;

    assign div_num   = mac_top[ACC_BITS-1] ? ACC_BITS'(-mac_top) : ACC_BITS'(mac_top);
    assign div_den   = mac_bot[BOT_BITS-1] ? BOT_BITS'(-mac_bot) : BOT_BITS'(mac_bot);
    assign div_start = (state_reg == ST_DRAIN) && mac_done && nan_reg && (mac_bot != '0);
    assign top_x     = 80'(mac_top);
    assign quo_x     = signed'(80'(div_quo));

    fbc_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .ACC_BITS    (ACC_BITS),
        .BOT_BITS    (BOT_BITS)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr      (mac_clr),
        .ctl      (ctl),
        .v        (v_sel),
        .c        (signed'(tap_rd_reg)),
        .done     (mac_done),
        .top      (mac_top),
        .bot      (mac_bot),
        .any_miss (mac_any_miss)
    );

    fbc_div #(
        .NUM_BITS (ACC_BITS),
        .DEN_BITS (BOT_BITS),
        .QUO_BITS (QUO_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (s_xfer && s_tuser == REQ_TAP && in_tap_index < TAP_AW'(MAX_TAPS)) begin
            tap_mem[in_tap_index] <= in_coef;
        end
        if (s_xfer && s_tuser == REQ_SAMPLE) begin
            win_mem[wp_reg] <= {in_missing, in_sample};
        end
        win_rd_reg <= win_mem[win_addr];
        tap_rd_reg <= tap_mem[k_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg        <= 5'd1;
            fill_reg      <= '0;
            fill_miss_reg <= 1'b0;
            skip_reg      <= 1'b0;
            nan_reg       <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HALF_WIDTH:   hw_reg        <= cfg_data[4:0];
                REG_FILL_VALUE:   fill_reg      <= signed'(cfg_data);
                REG_FILL_MISSING: fill_miss_reg <= cfg_data[0];
                REG_SKIP_FILL:    skip_reg      <= cfg_data[0];
                REG_NAN_MODE:     nan_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_center_reg) begin
            centre_val_reg  <= win_rd_reg[SAMPLE_BITS-1:0];
            centre_miss_reg <= win_rd_reg[SAMPLE_BITS];
            centre_in_reg   <= !s1_outside_reg;
        end
        s1_outside_reg <= outside;
        s1_last_reg    <= (k_reg == {hw_reg, 1'b0});
        s1_center_reg  <= (k_reg == {1'b0, hw_reg});
        if (state_reg == ST_DRAIN && mac_done) begin
            neg_reg <= mac_top[ACC_BITS-1] != mac_bot[BOT_BITS-1];
            if (nan_reg) begin
                res_val_reg  <= centre_in_reg ?
                    (VALUE_BITS'(centre_val_reg) <<< FRAC_BITS) : '0;
                res_miss_reg <= centre_in_reg ? centre_miss_reg : 1'b1;
            end else if (mac_any_miss) begin
                res_val_reg  <= '0;
                res_miss_reg <= 1'b1;
            end else begin
                res_val_reg  <= (top_x > VMAX) ? VALUE_BITS'(VMAX) :
                                (top_x < VMIN) ? VALUE_BITS'(VMIN) : VALUE_BITS'(top_x);
                res_miss_reg <= 1'b0;
            end
        end
        if (state_reg == ST_DIV && div_done) begin
            res_miss_reg <= 1'b0;
            if (neg_reg) begin
                res_val_reg <= (quo_x >= -VMIN) ? VALUE_BITS'(VMIN) : VALUE_BITS'(-quo_x);
            end else begin
                res_val_reg <= (quo_x > VMAX) ? VALUE_BITS'(VMAX) : VALUE_BITS'(quo_x);
            end
        end
        if (state_reg == ST_RES && out_free) begin
            m_tdata_reg <= OUT_TW'({res_miss_reg, res_val_reg});
            m_tlast_reg <= last_reg && (d_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            row_pos_reg  <= '0;
            pending_reg  <= '0;
            n_reg        <= '0;
            last_reg     <= 1'b0;
            d_reg        <= '0;
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= (state_reg == ST_EMIT);
            if (state_reg == ST_RES && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_xfer && s_tuser == REQ_SAMPLE) begin
                        wp_reg   <= wp_reg + 1'b1;
                        last_reg <= s_tlast;
                        n_reg    <= '0;
                        if (row_pos_reg != TAP_AW'(MAX_TAPS)) begin
                            row_pos_reg <= row_pos_reg + 1'b1;
                        end
                        if (pending_reg != TAP_AW'(MAX_TAPS)) begin
                            pending_reg <= pending_reg + 1'b1;
                        end
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (emit_go) begin
                        d_reg     <= pending_reg - 1'b1;
                        k_reg     <= '0;
                        state_reg <= ST_EMIT;
                    end else begin
                        if (last_reg) begin
                            row_pos_reg <= '0;
                            pending_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == {hw_reg, 1'b0}) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (mac_done) begin
                        state_reg <= div_start ? ST_DIV : ST_RES;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_RES;
                    end
                end
                ST_RES: begin
                    if (out_free) begin
                        pending_reg  <= pending_reg - 1'b1;
                        n_reg        <= n_reg + 1'b1;
                        state_reg    <= ST_CHECK;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_mac_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> state_reg == ST_DRAIN)
        else $error("accumulator finished outside drain");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide wait");

    a_tap_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> k_reg <= {hw_reg, 1'b0})
        else $error("tap counter ran past kernel end");

    a_result_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> n_reg < CNT_BITS'(MAX_RESULTS))
        else $error("too many results for one sample");

endmodule
`default_nettype wire

// ----- hdl/fbc_mac.sv -----
// Shared multiply-accumulate unit: one tap per cycle, product registered.
// Accumulates weighted sum, weight sum and a missing flag. Uses fbc_pkg.
`default_nettype none
module fbc_mac
    import fbc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = DEF_COEF_BITS,
    parameter int ACC_BITS    = SAMPLE_BITS + COEF_BITS + ACC_GUARD,
    parameter int BOT_BITS    = COEF_BITS + ACC_GUARD
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          clr,
    input  wire fbc_tap_ctl_t                  ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] v,
    input  wire logic signed [COEF_BITS-1:0]   c,
    output logic                               done,
    output logic signed [ACC_BITS-1:0]         top,
    output logic signed [BOT_BITS-1:0]         bot,
    output logic                               any_miss
);

    logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_reg;
    logic signed [COEF_BITS-1:0]             c_reg;
    logic                                    use_reg;
    logic                                    missv_reg;
    logic                                    lastp_reg;
    logic                                    done_reg;
    logic signed [ACC_BITS-1:0]              top_reg;
    logic signed [BOT_BITS-1:0]              bot_reg;
    logic                                    any_miss_reg;

    // ctl.last marks the final tap slot even when that tap is left out
    always_ff @(posedge aclk) begin
        prod_reg <= v * c;
        c_reg    <= c;
        if (!aresetn) begin
            use_reg   <= 1'b0;
            missv_reg <= 1'b0;
            lastp_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            use_reg   <= ctl.valid && !ctl.miss;
            missv_reg <= ctl.valid && ctl.miss;
            lastp_reg <= ctl.last;
            done_reg  <= lastp_reg;
        end
        if (clr) begin
            top_reg      <= '0;
            bot_reg      <= '0;
            any_miss_reg <= 1'b0;
        end else begin
            if (use_reg) begin
                top_reg <= top_reg + ACC_BITS'(prod_reg);
                bot_reg <= bot_reg + BOT_BITS'(c_reg);
            end
            if (missv_reg) begin
                any_miss_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign top      = top_reg;
    assign bot      = bot_reg;
    assign any_miss = any_miss_reg;

endmodule
`default_nettype wire

// ----- hdl/fbc_div.sv -----
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den.
// Unsigned operands; uses fbc_pkg for the fraction width.
`default_nettype none
module fbc_div
    import fbc_pkg::*;
#(
    parameter int NUM_BITS = DEF_SAMPLE_BITS + DEF_COEF_BITS + ACC_GUARD,
    parameter int DEN_BITS = DEF_COEF_BITS + ACC_GUARD,
    parameter int QUO_BITS = NUM_BITS + FRAC_BITS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     done,
    output logic [QUO_BITS-1:0]      quo
);

    localparam int CNT_BITS = $clog2(QUO_BITS + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [QUO_BITS-1:0] dvd_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic [DEN_BITS:0]   trial;
    logic                fits;

    assign trial = {rem_reg, dvd_reg[QUO_BITS-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(QUO_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            dvd_reg <= {num, FRAC_BITS'(0)};
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << 1;
            quo_reg <= {quo_reg[QUO_BITS-2:0], fits};
            rem_reg <= fits ? DEN_BITS'(trial - {1'b0, den_reg}) : trial[DEN_BITS-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire
